// ===== rtl/sdpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sector dual-pattern caseless match package
// Shared widths, reset values, register indexes, result codes and the
// ASCII case fold used by the pattern compare.
// ----------------------------------------------------------------------------
package sdpm_pkg;

    localparam int BYTE_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int LENGTH_W  = 4;
    localparam int CODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // "?BOOT-" and "?QUBOOT-", first character in the lowest byte.
    localparam logic [PATTERN_W-1:0] FIRST_PATTERN_RST  = 64'h0000_2D54_4F4F_423F;
    localparam logic [LENGTH_W-1:0]  FIRST_LENGTH_RST   = 4'd6;
    localparam logic [PATTERN_W-1:0] SECOND_PATTERN_RST = 64'h2D54_4F4F_4255_513F;
    localparam logic [LENGTH_W-1:0]  SECOND_LENGTH_RST  = 4'd8;

    localparam logic [BYTE_W-1:0] LOWER_A     = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_PATTERN  = 2'd0,
        CFG_FIRST_LENGTH   = 2'd1,
        CFG_SECOND_PATTERN = 2'd2,
        CFG_SECOND_LENGTH  = 2'd3
    } cfg_reg_t;

    localparam logic [CODE_W-1:0] MATCH_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] MATCH_FIRST  = 2'd1;
    localparam logic [CODE_W-1:0] MATCH_SECOND = 2'd2;

    // Folds ASCII lower-case letters to upper case; all other bytes pass.
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== rtl/sdpm_window_match.sv =====
// ----------------------------------------------------------------------------
// Window matcher
// Compares the newest bytes of the sector against one pattern, caseless,
// using the clamped pattern length and the number of bytes available.
// ----------------------------------------------------------------------------
module sdpm_window_match #(
    parameter int MAX_PATTERN = 8
) (
    // window[0] is the newest byte, window[i] lies i bytes earlier.
    input  logic [MAX_PATTERN-1:0][sdpm_pkg::BYTE_W-1:0] window,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]              avail,
    input  logic [sdpm_pkg::PATTERN_W-1:0]                pattern,
    input  logic [sdpm_pkg::LENGTH_W-1:0]                 length,
    output logic                                          hit
);

    localparam logic [sdpm_pkg::LENGTH_W-1:0] MAX_LEN = sdpm_pkg::LENGTH_W'(MAX_PATTERN);

    logic [sdpm_pkg::LENGTH_W-1:0] len_eff;
    logic [MAX_PATTERN-1:0]        cand_hit;
    logic                          sel_hit;

    always_comb
    begin
        if (length == '0)
        begin
            len_eff = sdpm_pkg::LENGTH_W'(1);
        end
        else if (length > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = length;
        end
    end

    // One candidate per possible length; pattern byte 0 lines up with the
    // oldest byte of the window of that length.
    always_comb
    begin
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            cand_hit[l-1] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (sdpm_pkg::fold_case(pattern[8*k +: 8]) !=
                    sdpm_pkg::fold_case(window[l-1-k]))
                begin
                    cand_hit[l-1] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        sel_hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            if (len_eff == sdpm_pkg::LENGTH_W'(l))
            begin
                sel_hit = cand_hit[l-1];
            end
        end
    end

    assign hit = (sdpm_pkg::LENGTH_W'(avail) >= len_eff) && sel_hit;

endmodule

// ===== rtl/sector_dual_pattern_caseless_match_top.sv =====
// ----------------------------------------------------------------------------
// Sector dual-pattern caseless match
// Streams the bytes of a sector and reports at its last byte whether the
// first pattern occurred, else whether the second one did.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Beat carries
//  s_axis    in         tvalid tready tdata[7:0] tlast  data_byte, sector_end
//  m_axis    out        tvalid tready tdata[7:0]        match_code (bits 1:0)
//  cfg       in         cfg_we cfg_index cfg_data       one register write
//
//  The block takes one byte beat in every cycle unless a last byte waits on a
//  stalled result. A byte is first captured in an input register; in the next
//  cycle both pattern compares run against that byte and the history, and on
//  the sector's last byte the result is loaded into the output register and
//  presented from there. The rate is set by the single compare stage.
//  Reset (rst_n low, asynchronous) clears the sector state and loads the
//  default patterns. A stalled result only holds back a last byte; ordinary
//  bytes keep flowing into the history while the result waits.
//
module sector_dual_pattern_caseless_match_top #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [7:0]                              s_axis_tdata,   // [7:0] data_byte
    input  logic                                    s_axis_tlast,   // sector_end

    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [7:0]                              m_axis_tdata,   // [1:0] match_code, rest zero

    input  logic                                    cfg_we,
    input  logic [sdpm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sdpm_pkg::PATTERN_W-1:0]          cfg_data
);

    // The history holds MAX_PATTERN-1 earlier bytes; one entry is kept even
    // when patterns are a single byte long.
    localparam int HIST_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int FILL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int AV_W   = $clog2(MAX_PATTERN + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN - 1);

    // Configuration registers.
    logic [sdpm_pkg::PATTERN_W-1:0] first_pattern_reg;
    logic [sdpm_pkg::LENGTH_W-1:0]  first_length_reg;
    logic [sdpm_pkg::PATTERN_W-1:0] second_pattern_reg;
    logic [sdpm_pkg::LENGTH_W-1:0]  second_length_reg;

    // Input register.
    logic                           st_valid_reg;
    logic [sdpm_pkg::BYTE_W-1:0]    st_data_reg;
    logic                           st_last_reg;

    // Sector state.
    logic [HIST_D-1:0][sdpm_pkg::BYTE_W-1:0] hist_reg;
    logic [FILL_W-1:0]              fill_reg;
    logic                           first_seen_reg;
    logic                           second_seen_reg;

    // Result register.
    logic                           m_valid_reg;
    logic [sdpm_pkg::CODE_W-1:0]    m_code_reg;
    logic [sdpm_pkg::CODE_W-1:0]    code_next;

    logic [MAX_PATTERN-1:0][sdpm_pkg::BYTE_W-1:0] window;
    logic [AV_W-1:0]                avail;
    logic                           first_hit;
    logic                           second_hit;
    logic                           first_any;
    logic                           second_any;
    logic                           out_free;
    logic                           advance;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pattern_reg  <= sdpm_pkg::FIRST_PATTERN_RST;
            first_length_reg   <= sdpm_pkg::FIRST_LENGTH_RST;
            second_pattern_reg <= sdpm_pkg::SECOND_PATTERN_RST;
            second_length_reg  <= sdpm_pkg::SECOND_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (sdpm_pkg::cfg_reg_t'(cfg_index))
                sdpm_pkg::CFG_FIRST_PATTERN:  first_pattern_reg  <= cfg_data;
                sdpm_pkg::CFG_FIRST_LENGTH:   first_length_reg   <= cfg_data[sdpm_pkg::LENGTH_W-1:0];
                sdpm_pkg::CFG_SECOND_PATTERN: second_pattern_reg <= cfg_data;
                sdpm_pkg::CFG_SECOND_LENGTH:  second_length_reg  <= cfg_data[sdpm_pkg::LENGTH_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // Only a last byte needs room in the result register; other bytes just
    // update the history and seen flags.
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign advance       = st_valid_reg && (!st_last_reg || out_free);
    assign s_axis_tready = !st_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            st_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            st_data_reg <= s_axis_tdata;
            st_last_reg <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Window and compares
    // ------------------------------------------------------------------
    always_comb
    begin
        window[0] = st_data_reg;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window[i] = hist_reg[i-1];
        end
    end

    // Bytes available in the window, including the current one.
    assign avail = AV_W'(fill_reg) + AV_W'(1);

    sdpm_window_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_first_match (
        .window  (window),
        .avail   (avail),
        .pattern (first_pattern_reg),
        .length  (first_length_reg),
        .hit     (first_hit)
    );

    sdpm_window_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_second_match (
        .window  (window),
        .avail   (avail),
        .pattern (second_pattern_reg),
        .length  (second_length_reg),
        .hit     (second_hit)
    );

    assign first_any  = first_seen_reg  || first_hit;
    assign second_any = second_seen_reg || second_hit;

    // The first pattern wins when both occurred.
    always_comb
    begin
        priority if (first_any)
        begin
            code_next = sdpm_pkg::MATCH_FIRST;
        end
        else if (second_any)
        begin
            code_next = sdpm_pkg::MATCH_SECOND;
        end
        else
        begin
            code_next = sdpm_pkg::MATCH_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Sector state
    // ------------------------------------------------------------------
    // History entries beyond the fill count are never compared, so the
    // history itself needs no clearing at a sector boundary.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hist_reg[0] <= st_data_reg;
            for (int i = 1; i < HIST_D; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            first_seen_reg  <= 1'b0;
            second_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (st_last_reg)
            begin
                fill_reg        <= '0;
                first_seen_reg  <= 1'b0;
                second_seen_reg <= 1'b0;
            end
            else
            begin
                if (fill_reg != FILL_MAX)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                first_seen_reg  <= first_any;
                second_seen_reg <= second_any;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance && st_last_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && st_last_reg)
        begin
            m_code_reg <= code_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(8 - sdpm_pkg::CODE_W){1'b0}}, m_code_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A result only appears after a last byte has gone through the compare.
    a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(advance && st_last_reg))
        else $error("result raised without a last byte");

    // The sector state starts afresh after a last byte.
    a_sector_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st_last_reg) |=>
            (!first_seen_reg && !second_seen_reg && fill_reg == '0))
        else $error("sector state not cleared after last byte");

    // A last byte held by a stalled result blocks new input.
    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && st_last_reg && m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a last byte is stalled");

    // The fill count saturates below the pattern limit.
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("history fill count out of range");

endmodule

// ===== tb/sv/tb_sector_dual_pattern_caseless_match_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sector dual-pattern caseless match testbench
// Streams sectors of bytes into the matcher and checks every per-sector match
// code against a local scoreboard model. The run covers directed sectors and
// random ones, several pattern settings and idle and stall patterns on both
// streams.
// ----------------------------------------------------------------------------
module tb_sector_dual_pattern_caseless_match_top;

    import sdpm_pkg::*;

    localparam int MAX_PATTERN   = 8;
    localparam int HIST_BYTES    = MAX_PATTERN - 1;
    localparam int RANDOM_BYTES  = 2000;
    localparam int PHASE_BYTES   = 220;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } sector_beat_t;

    // Clock, reset and stream signals. Every block input has a known value
    // from time zero.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // [7:0] data_byte
    logic                 s_axis_tlast = 1'b0;  // sector_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [1:0] match_code, [7:2] zero
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PATTERN_W-1:0] cfg_data = '0;

    // Idle control, written by the sequencer with nonblocking assignments so
    // the driver and the receiver always see the previous cycle's value.
    int  gap_pct = 0;
    int  stall_pct = 0;
    logic hold_armed = 1'b0;
    int  hold_count = 0;

    // Beats waiting for the driver, and match codes waiting for the output.
    sector_beat_t        beats_to_send[$];
    logic [CODE_W-1:0]   codes_due[$];

    // Scoreboard copy of the registers and of the per-sector scan state.
    logic [PATTERN_W-1:0] pat_first  = FIRST_PATTERN_RST;
    logic [LENGTH_W-1:0]  len_first  = FIRST_LENGTH_RST;
    logic [PATTERN_W-1:0] pat_second = SECOND_PATTERN_RST;
    logic [LENGTH_W-1:0]  len_second = SECOND_LENGTH_RST;
    logic [8*HIST_BYTES-1:0] byte_hist = '0;   // newest byte in the low bits
    int   hist_fill = 0;
    logic seen_first = 1'b0;
    logic seen_second = 1'b0;

    // Bookkeeping for the summary.
    int mismatches = 0;
    int quiet_cycles = 0;
    int random_bytes = 0;
    int sectors_sent = 0;
    int bytes_taken = 0;
    int codes_checked = 0;
    int settings_used = 1;
    int code_tally[4] = '{0, 0, 0, 0};

    sector_dual_pattern_caseless_match_top #(
        .MAX_PATTERN (MAX_PATTERN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scoreboard model of the matcher.
    // ------------------------------------------------------------------------

    // Lower-case ASCII letters compare as their upper-case form.
    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // A zero length acts as one byte, anything past eight as eight.
    function automatic int eff_len(input logic [LENGTH_W-1:0] l);
        if (l == 0)
        begin
            return 1;
        end
        if (l > MAX_PATTERN)
        begin
            return MAX_PATTERN;
        end
        return int'(l);
    endfunction

    // The window holds the newest byte in its low byte. The pattern's first
    // character must line up with the oldest byte of the compared span.
    function automatic bit window_hit(input logic [8*MAX_PATTERN-1:0] win, input int avail,
                                      input logic [PATTERN_W-1:0] pat,
                                      input logic [LENGTH_W-1:0] len_reg);
        int n;
        int k;
        n = eff_len(len_reg);
        if (avail < n)
        begin
            return 1'b0;
        end
        for (k = 0; k < n; k++)
        begin
            if (to_upper(pat[8*k +: 8]) != to_upper(win[8*(n-1-k) +: 8]))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advances the scan by one accepted byte; on the sector's last byte the
    // expected code is queued and the scan starts over.
    task automatic scan_sector_byte(input logic [7:0] b, input logic last);
        logic [8*MAX_PATTERN-1:0] win;
        logic [CODE_W-1:0]        code;
        win = {byte_hist, b};
        if (window_hit(win, hist_fill + 1, pat_first, len_first))
        begin
            seen_first = 1'b1;
        end
        if (window_hit(win, hist_fill + 1, pat_second, len_second))
        begin
            seen_second = 1'b1;
        end
        byte_hist = {byte_hist[8*HIST_BYTES-9:0], b};
        if (hist_fill < HIST_BYTES)
        begin
            hist_fill++;
        end
        if (last)
        begin
            code = seen_first ? MATCH_FIRST : (seen_second ? MATCH_SECOND : MATCH_NONE);
            codes_due.push_back(code);
            code_tally[code]++;
            byte_hist   = '0;
            hist_fill   = 0;
            seen_first  = 1'b0;
            seen_second = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("%0t: %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: puts the next pending byte on the input stream once the current
    // beat has gone, leaving random gaps as gap_pct asks.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        sector_beat_t next_beat;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                next_beat = beats_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_beat.data;
                s_axis_tlast  <= next_beat.last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once it is armed. The
    // hold-off is counted here so the sequencer need not step through it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_armed && hold_count < HOLD_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            hold_count++;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: the output beat is checked before the input beat of the same
    // edge is scanned, since a code can never come out in the cycle that
    // takes its last byte.
    always @(posedge clk)
    begin : watch_streams
        logic [CODE_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (codes_due.size() == 0)
                begin
                    flag_mismatch("match code with no finished sector", m_axis_tdata, 8'h00);
                end
                else
                begin
                    want = codes_due.pop_front();
                    if (m_axis_tdata[CODE_W-1:0] != want)
                    begin
                        flag_mismatch("match_code", {6'b0, m_axis_tdata[1:0]}, {6'b0, want});
                    end
                    if (m_axis_tdata[7:CODE_W] != '0)
                    begin
                        flag_mismatch("tdata padding", m_axis_tdata, {6'b0, want});
                    end
                    codes_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_sector_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
        end
    end

    // Watchdog: ends the run when no beat and no register write has moved for
    // too long. The long receiver hold-off stays well inside the limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles, %0d codes still due",
                             $time, QUIET_LIMIT, codes_due.size());
                    $display("sector_dual_pattern_caseless_match_top regression: fail");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    task automatic queue_body(input logic [7:0] body[$]);
        sector_beat_t beat;
        int i;
        for (i = 0; i < body.size(); i++)
        begin
            beat.data = body[i];
            beat.last = (i == body.size() - 1);
            beats_to_send.push_back(beat);
        end
        sectors_sent++;
    endtask

    task automatic queue_text(input string s);
        logic [7:0] body[$];
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            body.push_back(s[i]);
        end
        queue_body(body);
    endtask

    task automatic queue_lone_byte(input logic [7:0] b);
        logic [7:0] body[$];
        body.push_back(b);
        queue_body(body);
    endtask

    // Letters come back in either case; every other byte is left alone.
    function automatic logic [7:0] flip_case(input logic [7:0] c);
        logic [7:0] up;
        up = to_upper(c);
        if (up >= 8'h41 && up <= 8'h5A && $urandom_range(1) == 1)
        begin
            return up + 8'h20;
        end
        return up >= 8'h41 && up <= 8'h5A ? up : c;
    endfunction

    // Pattern characters lean on letters, on the bytes just outside the folded
    // range and on high-bit letter images, where a wrong fold would show.
    function automatic logic [7:0] pick_pattern_char();
        logic [7:0] edges[6] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1, 8'hE1};
        int r;
        r = $urandom_range(9);
        if (r < 5)
        begin
            return flip_case(8'h41 + 8'($urandom_range(25)));
        end
        if (r < 7)
        begin
            return edges[$urandom_range(5)];
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_data_byte();
        int r;
        int n;
        r = $urandom_range(9);
        if (r < 3)
        begin
            return 8'($urandom_range(255));
        end
        if (r < 7)
        begin
            if ($urandom_range(1) == 0)
            begin
                n = eff_len(len_first);
                return flip_case(pat_first[8*$urandom_range(n-1) +: 8]);
            end
            n = eff_len(len_second);
            return flip_case(pat_second[8*$urandom_range(n-1) +: 8]);
        end
        return pick_pattern_char();
    endfunction

    // Random sector: loose bytes mixed with whole pattern copies, some with
    // one byte spoiled and some cut short by the sector's end.
    task automatic queue_random_sector(input int max_len);
        logic [7:0]           body[$];
        logic [PATTERN_W-1:0] pat;
        int n;
        int k;
        int plen;
        n = ($urandom_range(11) == 0) ? $urandom_range(64, 25) : $urandom_range(max_len, 1);
        while (body.size() < n)
        begin
            if ($urandom_range(3) == 0)
            begin
                if ($urandom_range(1) == 0)
                begin
                    pat  = pat_first;
                    plen = eff_len(len_first);
                end
                else
                begin
                    pat  = pat_second;
                    plen = eff_len(len_second);
                end
                for (k = 0; k < plen; k++)
                begin
                    body.push_back(flip_case(pat[8*k +: 8]));
                end
                if ($urandom_range(4) == 0)
                begin
                    body[body.size() - 1 - $urandom_range(plen - 1)] = 8'($urandom_range(255));
                end
            end
            else
            begin
                body.push_back(pick_data_byte());
            end
        end
        while (body.size() > n)
        begin
            void'(body.pop_back());
        end
        queue_body(body);
        random_bytes += n;
    endtask

    // Register writes go out back to back with the enable held high; the
    // scoreboard copy changes with them, which is safe because the block is
    // idle whenever this runs.
    task automatic write_reg(input cfg_reg_t idx, input logic [PATTERN_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_FIRST_PATTERN:  pat_first  = value;
            CFG_FIRST_LENGTH:   len_first  = value[LENGTH_W-1:0];
            CFG_SECOND_PATTERN: pat_second = value;
            CFG_SECOND_LENGTH:  len_second = value[LENGTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [PATTERN_W-1:0] random_pattern();
        logic [PATTERN_W-1:0] p;
        int k;
        for (k = 0; k < MAX_PATTERN; k++)
        begin
            p[8*k +: 8] = pick_pattern_char();
        end
        return p;
    endfunction

    // Lengths are mostly legal, sometimes anywhere in 0..15, and sometimes
    // carry junk above the four register bits.
    function automatic logic [PATTERN_W-1:0] random_length_word();
        logic [PATTERN_W-1:0] w;
        w = '0;
        if ($urandom_range(1) == 0)
        begin
            w = {$urandom(), $urandom()};
        end
        w[LENGTH_W-1:0] = ($urandom_range(3) == 0) ? LENGTH_W'($urandom_range(15))
                                                    : LENGTH_W'($urandom_range(8, 1));
        return w;
    endfunction

    // The first setting uses the extreme patterns, the second makes both
    // patterns equal so both hit in the same place; the rest are random.
    task automatic choose_patterns(input int setting);
        logic [PATTERN_W-1:0] p;
        logic [PATTERN_W-1:0] l;
        if (setting == 0)
        begin
            write_reg(CFG_FIRST_PATTERN, '0);
            write_reg(CFG_FIRST_LENGTH, 64'd8);
            write_reg(CFG_SECOND_PATTERN, '1);
            write_reg(CFG_SECOND_LENGTH, 64'd15);
        end
        else if (setting == 1)
        begin
            p = random_pattern();
            l = random_length_word();
            write_reg(CFG_FIRST_PATTERN, p);
            write_reg(CFG_FIRST_LENGTH, l);
            write_reg(CFG_SECOND_PATTERN, p);
            write_reg(CFG_SECOND_LENGTH, l);
        end
        else
        begin
            write_reg(CFG_FIRST_PATTERN, random_pattern());
            write_reg(CFG_FIRST_LENGTH, random_length_word());
            write_reg(CFG_SECOND_PATTERN, random_pattern());
            write_reg(CFG_SECOND_LENGTH, random_length_word());
        end
        end_writes();
    endtask

    // The sender pauses here until every queued byte is taken and every code
    // has come out, then lets the pipeline settle before any register write.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (beats_to_send.size() != 0 || s_axis_tvalid || codes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int gap, input int stall);
        @(posedge clk);
        gap_pct   <= gap;
        stall_pct <= stall;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        int setting;
        int phase_start;
        int mode;
        int i;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed sectors under the reset patterns: a lower-case first
        // pattern that ends on the sector's last byte, one-byte sectors at
        // both byte extremes, the second pattern in mixed case (which holds
        // no copy of the first), and a sector too short for the first.
        @(negedge clk);
        queue_text("?boot-");
        queue_lone_byte(8'h00);
        queue_text("?QuBoOt-");
        queue_text("?BOOT");
        queue_lone_byte(8'hFF);
        wait_drained();

        // Unused high pattern bytes hold junk, and the second length is zero
        // so it acts as one byte. The first sector holds both patterns, so
        // the first must win; the second holds only the one-byte pattern.
        write_reg(CFG_FIRST_PATTERN, 64'hA5A5_A5A5_A5A5_6241);
        write_reg(CFG_FIRST_LENGTH, 64'd2);
        write_reg(CFG_SECOND_PATTERN, 64'h5A5A_5A5A_5A5A_5A62);
        write_reg(CFG_SECOND_LENGTH, 64'd0);
        end_writes();
        @(negedge clk);
        queue_text("aB");
        queue_text("xb");
        wait_drained();

        // Random phases. Each picks new patterns and takes the next of the four
        // idle modes in turn; the third one also holds the receiver off for a long
        // stretch while the sender keeps offering short sectors.
        setting = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            choose_patterns(setting);
            mode = setting % 4;
            case (mode)
                0: set_idling(0, 0);
                1: set_idling(64, 0);
                2: set_idling(0, 64);
                default: set_idling(14, 14);
            endcase
            @(negedge clk);
            phase_start = random_bytes;
            if (setting == 2)
            begin
                set_idling(0, 0);
                hold_armed <= 1'b1;
                @(negedge clk);
                for (i = 0; i < 60; i++)
                begin
                    queue_random_sector(3);
                end
            end
            while (random_bytes - phase_start < PHASE_BYTES)
            begin
                queue_random_sector(24);
            end
            wait_drained();
            setting++;
        end

        // Back to the reset patterns to close the run.
        write_reg(CFG_FIRST_PATTERN, FIRST_PATTERN_RST);
        write_reg(CFG_FIRST_LENGTH, 64'(FIRST_LENGTH_RST));
        write_reg(CFG_SECOND_PATTERN, SECOND_PATTERN_RST);
        write_reg(CFG_SECOND_LENGTH, 64'(SECOND_LENGTH_RST));
        end_writes();
        set_idling(14, 14);
        @(negedge clk);
        for (i = 0; i < 10; i++)
        begin
            queue_random_sector(16);
        end
        wait_drained();
        repeat (8) @(negedge clk);

        $display("Covered %0d sectors (%0d bytes taken) over %0d pattern settings.",
                 sectors_sent, bytes_taken, settings_used);
        $display("Checked %0d codes: %0d none, %0d first, %0d second only; %0d mismatches.",
                 codes_checked, code_tally[MATCH_NONE], code_tally[MATCH_FIRST],
                 code_tally[MATCH_SECOND], mismatches);
        if (mismatches == 0 && codes_due.size() == 0)
        begin
            $display("sector_dual_pattern_caseless_match_top regression: pass");
        end
        else
        begin
            $display("sector_dual_pattern_caseless_match_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sdpm_pkg.sv
rtl/sdpm_window_match.sv
rtl/sector_dual_pattern_caseless_match_top.sv
tb/sv/tb_sector_dual_pattern_caseless_match_top.sv
